>>> rtl/cdda_pkg.sv
package cdda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 23;
    localparam int ERR_W   = 2;

    localparam int MAX_YEAR_DEF    = 9999;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Day counts of the Gregorian cycles
    localparam int DAYS_400 = 146097;
    localparam int DAYS_100 = 36524;
    localparam int DAYS_4   = 1461;
    localparam int DAYS_1   = 365;

    localparam int DCOUNT_MAX = 4194303;
    localparam int DCOUNT_MIN = -4194304;

    localparam logic REQ_SHIFT = 1'b0;
    localparam logic REQ_DIFF  = 1'b1;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DATE  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_LEAP  = 5'd29;

    localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic                    req_type;
        logic                    bad;
        t_date                   prim;
        logic signed [OFF_W-1:0] offset;
        t_date                   other;
    } t_cmd;

    function automatic logic [DAY_W-1:0] f_month_days(input logic leap,
                                                      input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        if (m > MONTH_DEC) begin
            len = '0;
        end else if (m == MONTH_FEB && leap) begin
            len = DAY_LEAP;
        end else begin
            len = MONTH_LEN[m];
        end
        return len;
    endfunction

endpackage

>>> rtl/cdda_front.sv
module cdda_front
    import cdda_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                    i_start,
    input  logic                    i_full,
    input  logic                    i_req_type,
    input  logic [YEAR_W-1:0]       i_in_year,
    input  logic [MONTH_W-1:0]      i_in_month,
    input  logic [DAY_W-1:0]        i_in_day,
    input  logic signed [OFF_W-1:0] i_day_offset,
    input  logic [YEAR_W-1:0]       i_other_year,
    input  logic [MONTH_W-1:0]      i_other_month,
    input  logic [DAY_W-1:0]        i_other_day,
    output logic                    o_busy,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    // Structural check; Feb 29 of a common year is left to the back end
    function automatic logic f_bad(input t_date dt);
        return (dt.year == '0) || (32'(dt.year) > 32'(MAX_YEAR)) ||
               (dt.month == '0) || (dt.month > MONTH_DEC) ||
               (dt.day == '0) || (dt.day > f_month_days(1'b1, dt.month));
    endfunction

    t_date w_prim;
    t_date w_other;

    assign w_prim  = '{year: i_in_year, month: i_in_month, day: i_in_day};
    assign w_other = '{year: i_other_year, month: i_other_month, day: i_other_day};

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_cmd.req_type = i_req_type;
        o_cmd.prim     = w_prim;
        o_cmd.offset   = i_day_offset;
        o_cmd.other    = w_other;
        o_cmd.bad      = f_bad(w_prim) || ((i_req_type == REQ_DIFF) && f_bad(w_other));
    end

endmodule

>>> rtl/cdda_queue.sv
module cdda_queue
    import cdda_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/cdda_back.sv
module cdda_back
    import cdda_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  t_cmd                    i_cmd,
    output logic                    o_pop,
    output logic                    o_strobe,
    output logic [YEAR_W-1:0]       o_out_year,
    output logic [MONTH_W-1:0]      o_out_month,
    output logic [DAY_W-1:0]        o_out_day,
    output logic signed [OFF_W-1:0] o_day_count,
    output logic [ERR_W-1:0]        o_error
);

    localparam int TOTAL_DAYS = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                + MAX_YEAR / 400;
    localparam int TD_BITS = $clog2(TOTAL_DAYS + 1);
    localparam int NW      = ((TD_BITS > OFF_W) ? TD_BITS : OFF_W) + 2;
    localparam int YB      = $clog2(MAX_YEAR + 1);
    localparam int PW      = (YB > YEAR_W) ? YB : YEAR_W;

    localparam logic signed [NW-1:0] N_400   = NW'(DAYS_400);
    localparam logic signed [NW-1:0] N_100   = NW'(DAYS_100);
    localparam logic signed [NW-1:0] N_4     = NW'(DAYS_4);
    localparam logic signed [NW-1:0] N_1     = NW'(DAYS_1);
    localparam logic signed [NW-1:0] N_TOTAL = NW'(TOTAL_DAYS);
    localparam logic signed [NW-1:0] N_CMAX  = NW'(DCOUNT_MAX);
    localparam logic signed [NW-1:0] N_CMIN  = NW'(DCOUNT_MIN);

    typedef enum logic [3:0] {
        S_IDLE, S_D400, S_D100, S_D4, S_DYR, S_DMON, S_DEND,
        S_NCHK, S_N400, S_N100, S_N4, S_N1, S_NMON
    } t_state;

    t_state                 r_state;
    t_cmd                   r_cmd;
    logic                   r_second;
    logic [PW-1:0]          r_p;
    logic signed [NW-1:0]   r_acc;
    logic signed [NW-1:0]   r_n1;
    logic [1:0]             r_c100;
    logic [4:0]             r_q;
    logic [1:0]             r_yr;
    logic                   r_leap;
    logic [MONTH_W-1:0]     r_k;
    logic                   r_strobe;
    logic [YEAR_W-1:0]      r_out_year;
    logic [MONTH_W-1:0]     r_out_month;
    logic [DAY_W-1:0]       r_out_day;
    logic signed [OFF_W-1:0] r_day_count;
    logic [ERR_W-1:0]       r_error;

    t_date                w_cur;
    logic signed [NW-1:0] w_n;
    logic signed [NW-1:0] w_shift;
    logic signed [NW-1:0] w_diff;
    logic signed [NW-1:0] w_mdays;
    logic [OFF_W-1:0]     w_count;
    logic [10:0]          w_yr_days;
    logic                 w_leap_d;
    logic                 w_leap_n;

    assign w_cur   = r_second ? r_cmd.other : r_cmd.prim;
    assign w_n     = r_acc + signed'({{(NW - DAY_W){1'b0}}, w_cur.day}) - NW'(1);
    assign w_shift = w_n + signed'({{(NW - OFF_W){r_cmd.offset[OFF_W-1]}}, r_cmd.offset});
    assign w_diff  = r_n1 - w_n;
    assign w_mdays = signed'({{(NW - DAY_W){1'b0}}, f_month_days(r_leap, r_k)});

    // y = 400a + 100c + 4q + r + 1 is leap when r is 3, unless it closes a
    // century that is not the fourth one
    assign w_leap_d = (r_p[1:0] == 2'd3) && ((r_q != 5'd24) || (r_c100 == 2'd3));
    assign w_leap_n = (r_yr == 2'd3) && ((r_q != 5'd24) || (r_c100 == 2'd3));

    always_comb begin
        unique case (r_p[1:0])
            2'd0: w_yr_days = 11'd0;
            2'd1: w_yr_days = 11'd365;
            2'd2: w_yr_days = 11'd730;
            2'd3: w_yr_days = 11'd1095;
        endcase
    end

    always_comb begin
        if (w_diff > N_CMAX) begin
            w_count = N_CMAX[OFF_W-1:0];
        end else if (w_diff < N_CMIN) begin
            w_count = N_CMIN[OFF_W-1:0];
        end else begin
            w_count = w_diff[OFF_W-1:0];
        end
    end

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_strobe    = r_strobe;
    assign o_out_year  = r_out_year;
    assign o_out_month = r_out_month;
    assign o_out_day   = r_out_day;
    assign o_day_count = r_day_count;
    assign o_error     = r_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.bad) begin
                            r_strobe    <= 1'b1;
                            r_error     <= ERR_DATE;
                            r_out_year  <= '0;
                            r_out_month <= '0;
                            r_out_day   <= '0;
                            r_day_count <= '0;
                        end else begin
                            r_second <= 1'b0;
                            r_p      <= PW'(i_cmd.prim.year) - PW'(1);
                            r_acc    <= '0;
                            r_c100   <= '0;
                            r_q      <= '0;
                            r_state  <= S_D400;
                        end
                    end
                end
                // date to day number: peel cycles off year - 1
                S_D400: begin
                    if (r_p >= PW'(400)) begin
                        r_p   <= r_p - PW'(400);
                        r_acc <= r_acc + N_400;
                    end else begin
                        r_state <= S_D100;
                    end
                end
                S_D100: begin
                    if (r_p >= PW'(100)) begin
                        r_p    <= r_p - PW'(100);
                        r_acc  <= r_acc + N_100;
                        r_c100 <= r_c100 + 2'd1;
                    end else begin
                        r_state <= S_D4;
                    end
                end
                S_D4: begin
                    if (r_p >= PW'(4)) begin
                        r_p   <= r_p - PW'(4);
                        r_acc <= r_acc + N_4;
                        r_q   <= r_q + 5'd1;
                    end else begin
                        r_state <= S_DYR;
                    end
                end
                S_DYR: begin
                    r_acc   <= r_acc + signed'({{(NW - 11){1'b0}}, w_yr_days});
                    r_leap  <= w_leap_d;
                    r_k     <= 4'd1;
                    r_state <= S_DMON;
                end
                S_DMON: begin
                    if (r_k < w_cur.month) begin
                        r_acc <= r_acc + w_mdays;
                        r_k   <= r_k + 4'd1;
                    end else begin
                        r_state <= S_DEND;
                    end
                end
                S_DEND: begin
                    if (w_cur.month == MONTH_FEB && w_cur.day == DAY_LEAP && !r_leap) begin
                        r_strobe    <= 1'b1;
                        r_error     <= ERR_DATE;
                        r_out_year  <= '0;
                        r_out_month <= '0;
                        r_out_day   <= '0;
                        r_day_count <= '0;
                        r_state     <= S_IDLE;
                    end else if (r_second) begin
                        r_strobe    <= 1'b1;
                        r_error     <= ERR_OK;
                        r_out_year  <= '0;
                        r_out_month <= '0;
                        r_out_day   <= '0;
                        r_day_count <= signed'(w_count);
                        r_state     <= S_IDLE;
                    end else if (r_cmd.req_type == REQ_DIFF) begin
                        r_n1     <= w_n;
                        r_second <= 1'b1;
                        r_p      <= PW'(r_cmd.other.year) - PW'(1);
                        r_acc    <= '0;
                        r_c100   <= '0;
                        r_q      <= '0;
                        r_state  <= S_D400;
                    end else begin
                        r_acc   <= w_shift;
                        r_state <= S_NCHK;
                    end
                end
                S_NCHK: begin
                    if (r_acc < NW'(0) || r_acc >= N_TOTAL) begin
                        r_strobe    <= 1'b1;
                        r_error     <= ERR_RANGE;
                        r_out_year  <= '0;
                        r_out_month <= '0;
                        r_out_day   <= '0;
                        r_day_count <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_p     <= '0;
                        r_c100  <= '0;
                        r_q     <= '0;
                        r_yr    <= '0;
                        r_state <= S_N400;
                    end
                end
                // day number to date: rebuild year - 1 cycle by cycle
                S_N400: begin
                    if (r_acc >= N_400) begin
                        r_acc <= r_acc - N_400;
                        r_p   <= r_p + PW'(400);
                    end else begin
                        r_state <= S_N100;
                    end
                end
                S_N100: begin
                    if (r_c100 != 2'd3 && r_acc >= N_100) begin
                        r_acc  <= r_acc - N_100;
                        r_p    <= r_p + PW'(100);
                        r_c100 <= r_c100 + 2'd1;
                    end else begin
                        r_state <= S_N4;
                    end
                end
                S_N4: begin
                    if (r_acc >= N_4) begin
                        r_acc <= r_acc - N_4;
                        r_p   <= r_p + PW'(4);
                        r_q   <= r_q + 5'd1;
                    end else begin
                        r_state <= S_N1;
                    end
                end
                S_N1: begin
                    if (r_yr != 2'd3 && r_acc >= N_1) begin
                        r_acc <= r_acc - N_1;
                        r_p   <= r_p + PW'(1);
                        r_yr  <= r_yr + 2'd1;
                    end else begin
                        r_leap  <= w_leap_n;
                        r_k     <= 4'd1;
                        r_state <= S_NMON;
                    end
                end
                S_NMON: begin
                    if (r_k != MONTH_DEC && r_acc >= w_mdays) begin
                        r_acc <= r_acc - w_mdays;
                        r_k   <= r_k + 4'd1;
                    end else begin
                        r_strobe    <= 1'b1;
                        r_error     <= ERR_OK;
                        r_out_year  <= YEAR_W'(r_p + PW'(1));
                        r_out_month <= r_k;
                        r_out_day   <= r_acc[DAY_W-1:0] + 5'd1;
                        r_day_count <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/calendar_date_day_arithmetic.sv
// Flow: an item with a date field out of range is answered from the idle state; otherwise
//   each date is converted by stripping year cycles (year - 1 = 400a + 100c + 4q + r) and
//   walking months (month m), and a shift then adds a range check and walks back to a date.
// Queueing: the sequencer takes one item at a time, the next only once idle; the queue ahead
//   of it takes up to QUEUE_DEPTH items while it works, and busy is high only while it is full.
// Reset: synchronous, active low; clears queue and sequencer. o_strobe results cannot be stalled.
module calendar_date_day_arithmetic
    import cdda_pkg::*;
#(
    parameter int MAX_YEAR    = MAX_YEAR_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_req_type,
    input  logic [YEAR_W-1:0]       i_in_year,
    input  logic [MONTH_W-1:0]      i_in_month,
    input  logic [DAY_W-1:0]        i_in_day,
    input  logic signed [OFF_W-1:0] i_day_offset,
    input  logic [YEAR_W-1:0]       i_other_year,
    input  logic [MONTH_W-1:0]      i_other_month,
    input  logic [DAY_W-1:0]        i_other_day,
    output logic                    o_strobe,
    output logic [YEAR_W-1:0]       o_out_year,
    output logic [MONTH_W-1:0]      o_out_month,
    output logic [DAY_W-1:0]        o_out_day,
    output logic signed [OFF_W-1:0] o_day_count,
    output logic [ERR_W-1:0]        o_error
);

    // Front end: check the date fields and pack the request into one command
    // word. An item is taken whenever the queue has room, so busy is just
    // "queue full".
    //
    // Back end: a sequencer turns each date into a day count from 0001-01-01
    // by stripping 400, 100, 4 and 1 year cycles and then walking months.
    // A shift adds the offset, checks the range and walks the same cycles
    // back to a date. A difference converts both dates and subtracts,
    // saturating to the day_count width.

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    cdda_front #(
        .MAX_YEAR (MAX_YEAR)
    ) u_front (
        .i_start       (start),
        .i_full        (w_full),
        .i_req_type    (i_req_type),
        .i_in_year     (i_in_year),
        .i_in_month    (i_in_month),
        .i_in_day      (i_in_day),
        .i_day_offset  (i_day_offset),
        .i_other_year  (i_other_year),
        .i_other_month (i_other_month),
        .i_other_day   (i_other_day),
        .o_busy        (busy),
        .o_push        (w_push),
        .o_cmd         (w_cmd_in)
    );

    // Hold classified items until the sequencer is free
    cdda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_cmd_out)
    );

    cdda_back #(
        .MAX_YEAR (MAX_YEAR)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_out_year  (o_out_year),
        .o_out_month (o_out_month),
        .o_out_day   (o_out_day),
        .o_day_count (o_day_count),
        .o_error     (o_error)
    );

endmodule

>>> rtl/cdda_checker.sv
module cdda_checker
    import cdda_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_strobe,
    input logic [YEAR_W-1:0]       o_out_year,
    input logic [MONTH_W-1:0]      o_out_month,
    input logic [DAY_W-1:0]        o_out_day,
    input logic signed [OFF_W-1:0] o_day_count,
    input logic [ERR_W-1:0]        o_error
);

    // Drop any pending result on reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_error == ERR_OK || o_error == ERR_DATE || o_error == ERR_RANGE))
        else $error("undefined error code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_error != ERR_OK |->
            o_out_year == '0 && o_out_month == '0 && o_out_day == '0 && o_day_count == '0)
        else $error("error result carries data");

    a_shift_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_error == ERR_OK && o_out_month != '0 |->
            o_out_month <= MONTH_DEC && o_out_day != '0 && o_out_year != '0 &&
            o_day_count == '0)
        else $error("malformed shifted date");

    a_diff_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_error == ERR_OK && o_out_month == '0 |->
            o_out_year == '0 && o_out_day == '0)
        else $error("malformed difference result");

endmodule

bind calendar_date_day_arithmetic cdda_checker u_checker (.*);

>>> test/cdda_result_checker.sv
module cdda_result_checker
    import cdda_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic                    i_req_type,
    input  logic [YEAR_W-1:0]       i_in_year,
    input  logic [MONTH_W-1:0]      i_in_month,
    input  logic [DAY_W-1:0]        i_in_day,
    input  logic signed [OFF_W-1:0] i_day_offset,
    input  logic [YEAR_W-1:0]       i_other_year,
    input  logic [MONTH_W-1:0]      i_other_month,
    input  logic [DAY_W-1:0]        i_other_day,
    input  logic                    i_strobe,
    input  logic [YEAR_W-1:0]       i_out_year,
    input  logic [MONTH_W-1:0]      i_out_month,
    input  logic [DAY_W-1:0]        i_out_day,
    input  logic signed [OFF_W-1:0] i_day_count,
    input  logic [ERR_W-1:0]        i_error,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DAYS_IN_MONTH [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        t_date                   date;
        logic signed [OFF_W-1:0] count;
        logic [ERR_W-1:0]        err;
    } t_outcome;

    t_outcome outcome_q [$];
    int       fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic longint month_days(longint y, longint m);
        if (m < 1 || m > 12) begin
            return 0;
        end
        if (m == 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)) begin
            return 29;
        end
        return DAYS_IN_MONTH[m];
    endfunction

    // Days from 0001-01-01 to January 1 of year y
    function automatic longint days_to_jan1(longint y);
        longint p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic bit date_in_calendar(t_date d);
        return d.year >= 1 && d.year <= MAX_YEAR && d.month >= 1 && d.month <= 12 &&
               d.day >= 1 && d.day <= month_days(d.year, d.month);
    endfunction

    function automatic longint serial_day(t_date d);
        longint n;
        longint k;
        n = days_to_jan1(longint'(d.year)) + longint'(d.day) - 1;
        for (k = 1; k < d.month; k++) begin
            n += month_days(d.year, k);
        end
        return n;
    endfunction

    function automatic t_outcome predict_outcome(logic req, t_date prim,
                                                 logic signed [OFF_W-1:0] offset,
                                                 t_date other);
        t_outcome res;
        longint   n;
        longint   y;
        longint   m;
        longint   span;
        res = '0;
        if (req == REQ_SHIFT) begin
            if (!date_in_calendar(prim)) begin
                res.err = ERR_DATE;
                return res;
            end
            n = serial_day(prim) + longint'(offset);
            if (n < 0 || n >= days_to_jan1(MAX_YEAR + 1)) begin
                res.err = ERR_RANGE;
                return res;
            end
            // estimate the year from the 400-year cycle, then settle it
            y = n * 400 / 146097 + 1;
            while (y > 1 && days_to_jan1(y) > n) begin
                y--;
            end
            while (days_to_jan1(y + 1) <= n) begin
                y++;
            end
            n -= days_to_jan1(y);
            m = 1;
            while (m < 12 && n >= month_days(y, m)) begin
                n -= month_days(y, m);
                m++;
            end
            res.date.year  = YEAR_W'(y);
            res.date.month = MONTH_W'(m);
            res.date.day   = DAY_W'(n + 1);
        end else begin
            if (!date_in_calendar(prim) || !date_in_calendar(other)) begin
                res.err = ERR_DATE;
                return res;
            end
            span = serial_day(prim) - serial_day(other);
            if (span > DCOUNT_MAX) begin
                span = DCOUNT_MAX;
            end
            if (span < DCOUNT_MIN) begin
                span = DCOUNT_MIN;
            end
            res.count = OFF_W'(span);
        end
        return res;
    endfunction

    task automatic note_mismatch(string field, longint exp_val, longint got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", field, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            outcome_q.delete();
        end else begin
            if (i_strobe) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no item pending");
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    note_mismatch("out_year", want.date.year, i_out_year);
                    note_mismatch("out_month", want.date.month, i_out_month);
                    note_mismatch("out_day", want.date.day, i_out_day);
                    note_mismatch("day_count", $signed(want.count), i_day_count);
                    note_mismatch("error", want.err, i_error);
                end
            end
            if (i_start && !i_busy) begin
                outcome_q.push_back(predict_outcome(i_req_type,
                    t_date'{i_in_year, i_in_month, i_in_day}, i_day_offset,
                    t_date'{i_other_year, i_other_month, i_other_day}));
            end
        end
        o_pending <= outcome_q.size();
    end

endmodule

>>> test/calendar_date_day_arithmetic_tb.sv
module calendar_date_day_arithmetic_tb
    import cdda_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RANDOM_ITEMS = 115;
    // Last shift that still lands inside the calendar: 0001-01-01 to 9999-12-31
    localparam int FULL_SPAN    = 3652058;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    start         = 1'b0;
    logic                    busy;
    logic                    req_type      = REQ_SHIFT;
    logic [YEAR_W-1:0]       in_year       = '0;
    logic [MONTH_W-1:0]      in_month      = '0;
    logic [DAY_W-1:0]        in_day        = '0;
    logic signed [OFF_W-1:0] day_offset    = '0;
    logic [YEAR_W-1:0]       other_year    = '0;
    logic [MONTH_W-1:0]      other_month   = '0;
    logic [DAY_W-1:0]        other_day     = '0;
    logic                    strobe;
    logic [YEAR_W-1:0]       out_year;
    logic [MONTH_W-1:0]      out_month;
    logic [DAY_W-1:0]        out_day;
    logic signed [OFF_W-1:0] day_count;
    logic [ERR_W-1:0]        error_code;
    int                      fail_count;
    int                      pending;
    int                      burst_left = 0;

    // Free-running clock
    always #(CLK_HALF) i_clk = ~i_clk;

    calendar_date_day_arithmetic #(
        .MAX_YEAR    (MAX_YEAR_DEF),
        .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (req_type),
        .i_in_year     (in_year),
        .i_in_month    (in_month),
        .i_in_day      (in_day),
        .i_day_offset  (day_offset),
        .i_other_year  (other_year),
        .i_other_month (other_month),
        .i_other_day   (other_day),
        .o_strobe      (strobe),
        .o_out_year    (out_year),
        .o_out_month   (out_month),
        .o_out_day     (out_day),
        .o_day_count   (day_count),
        .o_error       (error_code)
    );

    // Watch both sides, predict every accepted item and compare its result
    cdda_result_checker #(
        .MAX_YEAR (MAX_YEAR_DEF)
    ) u_result_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req_type    (req_type),
        .i_in_year     (in_year),
        .i_in_month    (in_month),
        .i_in_day      (in_day),
        .i_day_offset  (day_offset),
        .i_other_year  (other_year),
        .i_other_month (other_month),
        .i_other_day   (other_day),
        .i_strobe      (strobe),
        .i_out_year    (out_year),
        .i_out_month   (out_month),
        .i_out_day     (out_day),
        .i_day_count   (day_count),
        .i_error       (error_code),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic t_date ymd(int y, int m, int d);
        return t_date'{YEAR_W'(y), MONTH_W'(m), DAY_W'(d)};
    endfunction

    // Calendar-correct date; years near both ends of the range and century years show up often
    function automatic t_date any_valid_date();
        int  y;
        int  m;
        bit  leap;
        case ($urandom_range(0, 7))
            0:       y = $urandom_range(1, 5);
            1:       y = $urandom_range(MAX_YEAR_DEF - 4, MAX_YEAR_DEF);
            2:       y = 400 * $urandom_range(1, 24) + $urandom_range(0, 1) * 100;
            default: y = $urandom_range(1, MAX_YEAR_DEF);
        endcase
        m    = $urandom_range(1, 12);
        leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
        return ymd(y, m, $urandom_range(1, f_month_days(leap, MONTH_W'(m))));
    endfunction

    // Anything the field widths allow, valid or not
    function automatic t_date any_raw_date();
        return ymd($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    endfunction

    function automatic logic signed [OFF_W-1:0] any_offset();
        case ($urandom_range(0, 4))
            0:       return OFF_W'($urandom_range(0, 800) - 400);
            1:       return OFF_W'($urandom_range(0, 8000) - 4000);
            2:       return OFF_W'($urandom_range(0, 800000) - 400000);
            3:       return OFF_W'($urandom_range(0, 2 * FULL_SPAN) - FULL_SPAN);
            default: return OFF_W'($urandom);
        endcase
    endfunction

    // Drop start at the next falling edge and hold it low until the task returns
    task automatic idle_cycles(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Sender runs in bursts; a gap (sometimes none, sometimes long) opens each burst
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(20, 180);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                idle_cycles(gap);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    // Present one item at the falling edge and hold it until it is taken.
    // start stays high into the next item of a burst, so it gets one
    // assignment per falling edge.
    task automatic send_item(logic req, t_date prim, logic signed [OFF_W-1:0] offset,
                             t_date other);
        pace();
        @(negedge i_clk);
        start       <= 1'b1;
        req_type    <= req;
        in_year     <= prim.year;
        in_month    <= prim.month;
        in_day      <= prim.day;
        day_offset  <= offset;
        other_year  <= other.year;
        other_month <= other.month;
        other_day   <= other.day;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin : stimulus
        t_date none;
        int    i;
        int    roll;
        none = '0;

        // Hold reset low, then release it at a falling edge
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Leap-year rules around February: divisible by 400, plain century, leap day; then a year end and a zero shift
        send_item(REQ_SHIFT, ymd(2000, 2, 28), 1, none);
        send_item(REQ_SHIFT, ymd(1900, 2, 28), 1, none);
        send_item(REQ_SHIFT, ymd(2004, 2, 29), 365, none);
        send_item(REQ_SHIFT, ymd(2004, 12, 31), 1, none);
        send_item(REQ_SHIFT, ymd(2023, 6, 15), 0, none);
        // Whole calendar span in both directions, and past its ends by one day and by the largest offset
        send_item(REQ_SHIFT, ymd(1, 1, 1), OFF_W'(FULL_SPAN), none);
        send_item(REQ_SHIFT, ymd(MAX_YEAR_DEF, 12, 31), OFF_W'(-FULL_SPAN), none);
        send_item(REQ_SHIFT, ymd(1, 1, 1), -1, none);
        send_item(REQ_SHIFT, ymd(MAX_YEAR_DEF, 12, 31), 1, none);
        send_item(REQ_SHIFT, ymd(1, 1, 1), OFF_W'(DCOUNT_MAX), none);
        send_item(REQ_SHIFT, ymd(MAX_YEAR_DEF, 12, 31), OFF_W'(DCOUNT_MIN), none);
        // Bad primary dates; the second date is ignored by a shift
        send_item(REQ_SHIFT, ymd(0, 1, 1), 5, ymd(16383, 15, 31));
        send_item(REQ_SHIFT, ymd(MAX_YEAR_DEF + 1, 1, 1), 5, none);
        send_item(REQ_SHIFT, ymd(16383, 15, 31), -1, none);
        send_item(REQ_SHIFT, ymd(2020, 0, 10), 5, none);
        send_item(REQ_SHIFT, ymd(2020, 13, 10), 5, none);
        send_item(REQ_SHIFT, ymd(2020, 5, 0), 5, none);
        send_item(REQ_SHIFT, ymd(2021, 4, 31), 5, none);
        send_item(REQ_SHIFT, ymd(1900, 2, 29), 5, none);
        send_item(REQ_SHIFT, ymd(2000, 2, 30), 5, none);
        // Differences: full span both ways, zero, and bad dates on either side
        send_item(REQ_DIFF, ymd(MAX_YEAR_DEF, 12, 31), -1, ymd(1, 1, 1));
        send_item(REQ_DIFF, ymd(1, 1, 1), 0, ymd(MAX_YEAR_DEF, 12, 31));
        send_item(REQ_DIFF, ymd(2024, 3, 1), 0, ymd(2024, 3, 1));
        send_item(REQ_DIFF, ymd(2024, 3, 1), 0, ymd(16383, 15, 31));
        send_item(REQ_DIFF, ymd(2023, 2, 29), 0, ymd(2024, 3, 1));

        // Random part: mostly well-formed requests, with some raw noise
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            // Halfway, let the block drain completely before going on
            if (i == RANDOM_ITEMS / 2) begin
                idle_cycles(1);
                wait (pending == 0);
            end
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                send_item(1'($urandom_range(0, 1)), any_raw_date(), OFF_W'($urandom),
                          any_raw_date());
            end else if (roll <= 5) begin
                send_item(REQ_SHIFT, any_valid_date(), any_offset(), any_raw_date());
            end else if (roll <= 8) begin
                send_item(REQ_DIFF, any_valid_date(), OFF_W'($urandom), any_valid_date());
            end else begin
                send_item(REQ_DIFF, any_valid_date(), OFF_W'($urandom), any_raw_date());
            end
        end

        // Drain: wait for the last result, then give stray strobes time to show
        idle_cycles(1);
        wait (pending == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("calendar_date_day_arithmetic_tb passed");
        end else begin
            $display("calendar_date_day_arithmetic_tb failed");
        end
        $finish;
    end

    // Watchdog: a correct run, even with the slowest items and longest gaps, needs a small
    // fraction of this
    initial begin : watchdog
        #5_000_000;
        $display("calendar_date_day_arithmetic_tb failed");
        $finish;
    end

endmodule
